>>> hdl/utf8v_pkg.sv
// Shared types and constants for the bounded UTF-8 text validator.
// Used by utf8v_step and utf8_bounded_text_validator; depends on nothing.
package utf8v_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned PEND_W  = 2;

  // Limit register reset value and count ceiling
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd256;
  localparam logic [COUNT_W-1:0] COUNT_CAP   = 11'h7FF;

  // Byte classes and second-byte bounds
  localparam logic [BYTE_W-1:0] BYTE_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_DEL     = 8'h7F;
  localparam logic [BYTE_W-1:0] BYTE_CONT_LO = 8'h80;
  localparam logic [BYTE_W-1:0] BYTE_CONT_HI = 8'hBF;
  localparam logic [BYTE_W-1:0] BYTE_L2_LO   = 8'hC2;
  localparam logic [BYTE_W-1:0] BYTE_L2_HI   = 8'hDF;
  localparam logic [BYTE_W-1:0] BYTE_L3_LO   = 8'hE0;
  localparam logic [BYTE_W-1:0] BYTE_L3_HI   = 8'hEF;
  localparam logic [BYTE_W-1:0] BYTE_L4_LO   = 8'hF0;
  localparam logic [BYTE_W-1:0] BYTE_L4_HI   = 8'hF4;
  localparam logic [BYTE_W-1:0] BYTE_ED      = 8'hED;
  localparam logic [BYTE_W-1:0] BYTE_A0      = 8'hA0;
  localparam logic [BYTE_W-1:0] BYTE_9F      = 8'h9F;
  localparam logic [BYTE_W-1:0] BYTE_90      = 8'h90;
  localparam logic [BYTE_W-1:0] BYTE_8F      = 8'h8F;

  // Continuation counts set by each lead class
  localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
  localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

  // Per-string decoder state
  typedef struct packed {
    logic [PEND_W-1:0]  pend;
    logic [BYTE_W-1:0]  lead;
    logic               at_second;
    logic               err;
    logic [COUNT_W-1:0] count;
    logic               any;
  } utf8v_state_t;

  // Verdict for a closing transaction
  typedef struct packed {
    logic               valid_res;
    logic [COUNT_W-1:0] count;
  } utf8v_verdict_t;

endpackage

>>> hdl/utf8v_step.sv
// Combinational next-state and verdict logic for one input transaction.
// Depends on utf8v_pkg.
module utf8v_step import utf8v_pkg::*; (
  input  utf8v_state_t        cur_st,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                has_byte,
  input  logic                last,
  input  logic [COUNT_W-1:0]  max_points,
  output utf8v_state_t        nxt_st,
  output utf8v_verdict_t      verdict
);

  utf8v_state_t       byte_st;
  logic               do_count;
  logic [COUNT_W:0]   cnt_inc;
  logic               bad_second;

  // Count increment with overflow and cap
  assign cnt_inc = {1'b0, cur_st.count} + {{COUNT_W{1'b0}}, 1'b1};

  // Overlong and surrogate limits on the second byte
  assign bad_second = ((cur_st.lead == BYTE_L3_LO) && (data_byte < BYTE_A0)) ||
                      ((cur_st.lead == BYTE_ED)    && (data_byte > BYTE_9F)) ||
                      ((cur_st.lead == BYTE_L4_LO) && (data_byte < BYTE_90)) ||
                      ((cur_st.lead == BYTE_L4_HI) && (data_byte > BYTE_8F));

  // Decode one byte against the current state
  always_comb begin
    byte_st  = cur_st;
    do_count = 1'b0;
    if (has_byte) begin
      byte_st.any = 1'b1;
      if (!cur_st.err) begin
        if (cur_st.pend == PEND_NONE) begin
          if (data_byte <= BYTE_DEL) begin
            if ((data_byte < BYTE_SPACE) || (data_byte == BYTE_DEL)) begin
              byte_st.err = 1'b1;
            end else begin
              do_count = 1'b1;
            end
          end else if ((data_byte >= BYTE_L2_LO) && (data_byte <= BYTE_L2_HI)) begin
            byte_st.pend      = PEND_ONE;
            byte_st.lead      = data_byte;
            byte_st.at_second = 1'b1;
          end else if ((data_byte >= BYTE_L3_LO) && (data_byte <= BYTE_L3_HI)) begin
            byte_st.pend      = PEND_TWO;
            byte_st.lead      = data_byte;
            byte_st.at_second = 1'b1;
          end else if ((data_byte >= BYTE_L4_LO) && (data_byte <= BYTE_L4_HI)) begin
            byte_st.pend      = PEND_THREE;
            byte_st.lead      = data_byte;
            byte_st.at_second = 1'b1;
          end else begin
            byte_st.err = 1'b1;
          end
        end else if ((data_byte < BYTE_CONT_LO) || (data_byte > BYTE_CONT_HI)) begin
          byte_st.err = 1'b1;
        end else if (cur_st.at_second && bad_second) begin
          byte_st.err = 1'b1;
        end else begin
          byte_st.at_second = 1'b0;
          byte_st.pend      = cur_st.pend - PEND_ONE;
          do_count          = (cur_st.pend == PEND_ONE);
        end
      end
    end
    // Count a completed code point, flag overrun of the limit
    if (do_count) begin
      if (cnt_inc > {1'b0, max_points}) begin
        byte_st.err = 1'b1;
      end
      byte_st.count = cnt_inc[COUNT_W] ? COUNT_CAP : cnt_inc[COUNT_W-1:0];
    end
  end

  // Verdict from the state after the byte, then clear on end of string
  assign verdict.valid_res = byte_st.any && !byte_st.err && (byte_st.pend == PEND_NONE);
  assign verdict.count     = byte_st.count;
  assign nxt_st            = last ? '0 : byte_st;

endmodule

>>> hdl/utf8_bounded_text_validator.sv
// Top level of the bounded UTF-8 text validator: input register, decoder
// state, limit register and verdict register. Depends on utf8v_pkg, utf8v_step.
//
// The block takes one string byte per transaction and accepts a transaction in
// every cycle, one byte per clock sustained, unless a closing transaction waits
// in the input register for a full verdict register. A transaction passes through
// the input register and is then decoded against the per-string state; a closing
// transaction (tlast) loads the verdict register when it is decoded.
// The verdict register holds one result; while it is stalled, bytes without
// tlast keep flowing and only the next closing transaction waits. tuser = 0
// marks a transaction with no byte, used to close a string after its last byte.
// The user must write the code-point limit through cfg_wr_en/cfg_wr_data only
// between strings (the block does not enforce this); it resets to 256.
module utf8_bounded_text_validator import utf8v_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // Limit register write
  input  logic                cfg_wr_en,
  input  logic [COUNT_W-1:0]  cfg_wr_data,   // max_code_points
  // Byte stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [BYTE_W-1:0]   in_tdata,      // [7:0] data_byte
  input  logic                in_tuser,      // [0] has_byte
  input  logic                in_tlast,      // end of string
  // Verdict stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata      // [0] valid_res, [11:1] code_point_count, [15:12] zero
);

  logic [COUNT_W-1:0] limit_r;
  logic               in_valid_r;
  logic [BYTE_W-1:0]  in_byte_r;
  logic               in_has_r;
  logic               in_last_r;
  utf8v_state_t       st_r;
  utf8v_state_t       st_nxt;
  utf8v_verdict_t     verdict_nxt;
  utf8v_verdict_t     res_r;
  logic               out_valid_r;
  logic               advance;

  // Process the held transaction unless it closes a string and the result slot is full and not being taken
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_has_r  <= in_tuser;
      in_last_r <= in_tlast;
    end
  end

  // Byte decoder
  utf8v_step u_step (
    .cur_st     (st_r),
    .data_byte  (in_byte_r),
    .has_byte   (in_has_r),
    .last       (in_last_r),
    .max_points (limit_r),
    .nxt_st     (st_nxt),
    .verdict    (verdict_nxt)
  );

  // Advance the string state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Verdict register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      res_r <= verdict_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r.count, res_r.valid_res};

  // String state is cleared after every verdict
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_last_r) |=> (st_r == '0))
    else $error("string state not cleared after closing transaction");

  // A verdict appears only after a closing transaction was processed
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && in_last_r))
    else $error("verdict loaded without a closing transaction");

  // Pending continuations always follow a legal multi-byte lead
  a_pend_has_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.pend != PEND_NONE) |-> ((st_r.lead >= BYTE_L2_LO) && (st_r.lead <= BYTE_L4_HI)))
    else $error("continuations pending without a lead byte");

  // Second-byte check only while a character is open
  a_second_in_char: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.at_second |-> (st_r.pend != PEND_NONE))
    else $error("second-byte flag set outside a character");

endmodule

>>> verif/utf8_bounded_text_validator_tb.sv
// Self-checking testbench for utf8_bounded_text_validator: streams strings of
// bytes in, predicts each end-of-string verdict and checks it on the result port.
// Depends on utf8v_pkg and the validator RTL.
module utf8_bounded_text_validator_tb;
  import utf8v_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;
  logic               in_tvalid;
  logic               in_tready;
  logic [BYTE_W-1:0]  in_tdata;     // [7:0] data_byte
  logic               in_tuser;     // [0] has_byte
  logic               in_tlast;     // end of string
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [15:0]        out_tdata;    // [0] valid_res, [11:1] code_point_count, [15:12] zero

  // Mirror of the decoder state and the limit register
  logic [COUNT_W-1:0] limit_q;
  logic [PEND_W-1:0]  cont_left;
  logic [BYTE_W-1:0]  first_lead;
  logic               expect_second;
  logic               bad_string;
  logic [COUNT_W-1:0] points;
  logic               seen_byte;

  utf8v_verdict_t     verdicts_due[$];
  int                 mismatches = 0;
  int                 items_sent = 0;
  int                 cycle_count = 0;
  int                 stall_left = 0;
  bit                 idle_on = 1'b1;
  bit                 noise_on = 1'b0;

  utf8_bounded_text_validator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Verdict predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_string();
    cont_left     = PEND_NONE;
    first_lead    = '0;
    expect_second = 1'b0;
    bad_string    = 1'b0;
    points        = '0;
    seen_byte     = 1'b0;
  endfunction

  // Count one finished code point; the one past the limit is kept and flags the string
  function automatic void count_code_point();
    int unsigned nxt;
    nxt = points + 1;
    if (nxt > limit_q) bad_string = 1'b1;
    points = (nxt > COUNT_CAP) ? COUNT_CAP : nxt[COUNT_W-1:0];
  endfunction

  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    seen_byte = 1'b1;
    // A bad string stays bad; later bytes are not decoded
    if (bad_string) return;
    if (cont_left == PEND_NONE) begin
      if (b <= BYTE_DEL) begin
        if (b < BYTE_SPACE || b == BYTE_DEL) bad_string = 1'b1;
        else count_code_point();
        return;
      end
      if (b >= BYTE_L2_LO && b <= BYTE_L2_HI) cont_left = PEND_ONE;
      else if (b >= BYTE_L3_LO && b <= BYTE_L3_HI) cont_left = PEND_TWO;
      else if (b >= BYTE_L4_LO && b <= BYTE_L4_HI) cont_left = PEND_THREE;
      else begin
        bad_string = 1'b1;
        return;
      end
      first_lead    = b;
      expect_second = 1'b1;
      return;
    end
    if (b < BYTE_CONT_LO || b > BYTE_CONT_HI) begin
      bad_string = 1'b1;
      return;
    end
    // Overlong and surrogate bounds apply to the second byte only
    if (expect_second) begin
      if ((first_lead == BYTE_L3_LO && b < BYTE_A0) || (first_lead == BYTE_ED && b > BYTE_9F) ||
          (first_lead == BYTE_L4_LO && b < BYTE_90) || (first_lead == BYTE_L4_HI && b > BYTE_8F)) begin
        bad_string = 1'b1;
        return;
      end
      expect_second = 1'b0;
    end
    cont_left = cont_left - 1'b1;
    if (cont_left == PEND_NONE) count_code_point();
  endfunction

  function automatic void apply_item(input logic [BYTE_W-1:0] b, input logic has, input logic last);
    utf8v_verdict_t v;
    if (has) decode_byte(b);
    if (last) begin
      v.valid_res = seen_byte && !bad_string && cont_left == PEND_NONE;
      v.count     = points;
      verdicts_due.push_back(v);
      clear_string();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts and the verdict check
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!idle_on) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void record_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endfunction

  always @(posedge clk) begin : check_verdicts
    utf8v_verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_due.size() == 0) begin
        record_mismatch($sformatf("verdict valid=%0b count=%0d with none due",
                                  out_tdata[0], out_tdata[11:1]));
      end else begin
        want = verdicts_due.pop_front();
        if (out_tdata[0] !== want.valid_res || out_tdata[11:1] !== want.count)
          record_mismatch($sformatf("expected valid=%0b count=%0d, got valid=%0b count=%0d",
                                    want.valid_res, want.count, out_tdata[0], out_tdata[11:1]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one transaction and hold it until taken; returns at the next falling edge
  task automatic send_item(input logic [BYTE_W-1:0] b, input logic has, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= has;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_item(b, has, last);
    if (has || last) items_sent++;
    @(negedge clk);
  endtask

  // Send a string, closing on its final byte or with a separate byteless transaction
  task automatic send_string(input byte_q_t s, input bit close_on_byte);
    foreach (s[i]) begin
      if (noise_on && $urandom_range(0, 15) == 0)
        send_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(s[i], 1'b1, close_on_byte && i == s.size() - 1);
    end
    if (!close_on_byte || s.size() == 0)
      send_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic send_ascii_run(input int n);
    byte_q_t s;
    repeat (n) s.push_back(BYTE_W'($urandom_range(8'h20, 8'h7E)));
    send_string(s, 1'($urandom_range(0, 1)));
  endtask

  // Write the limit once the block has drained
  task automatic set_limit(input logic [COUNT_W-1:0] value);
    in_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    limit_q = value;
  endtask

  // Mostly well-formed strings of random characters, some damaged, some pure noise
  task automatic send_random_string();
    byte_q_t            s;
    int                 n;
    logic [BYTE_W-1:0]  lead_b;
    logic [BYTE_W-1:0]  second_b;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 8)) s.push_back(BYTE_W'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(0, 10);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: s.push_back(BYTE_W'($urandom_range(8'h20, 8'h7E)));
          1: begin
            s.push_back(BYTE_W'($urandom_range(8'hC2, 8'hDF)));
            s.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
          end
          2: begin
            lead_b = BYTE_W'($urandom_range(8'hE0, 8'hEF));
            if (lead_b == BYTE_L3_LO) second_b = BYTE_W'($urandom_range(8'hA0, 8'hBF));
            else if (lead_b == BYTE_ED) second_b = BYTE_W'($urandom_range(8'h80, 8'h9F));
            else second_b = BYTE_W'($urandom_range(8'h80, 8'hBF));
            s.push_back(lead_b);
            s.push_back(second_b);
            s.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
          end
          default: begin
            lead_b = BYTE_W'($urandom_range(8'hF0, 8'hF4));
            if (lead_b == BYTE_L4_LO) second_b = BYTE_W'($urandom_range(8'h90, 8'hBF));
            else if (lead_b == BYTE_L4_HI) second_b = BYTE_W'($urandom_range(8'h80, 8'h8F));
            else second_b = BYTE_W'($urandom_range(8'h80, 8'hBF));
            s.push_back(lead_b);
            s.push_back(second_b);
            s.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
            s.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
          end
        endcase
      end
      // Damage a few: corrupt a byte, cut the tail, or slip in a stray byte
      case ($urandom_range(0, 11))
        0: if (s.size() > 0) s[$urandom_range(0, s.size() - 1)] = BYTE_W'($urandom_range(0, 255));
        1: if (s.size() > 0) void'(s.pop_back());
        2: s.insert($urandom_range(0, s.size()), BYTE_W'($urandom_range(0, 255)));
        default: ;
      endcase
    end
    send_string(s, 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_well_formed();
    // Empty string
    send_item(8'h5A, 1'b0, 1'b1);
    // ASCII space, the top of each multi-byte class and the upper second-byte bounds
    send_string('{8'h20, 8'hDF, 8'hBF, 8'hED, 8'h9F, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b1);
    // Transaction with neither byte nor end
    send_item(8'hA5, 1'b0, 1'b0);
    // ASCII tilde, the bottom of each multi-byte class and the lower second-byte bounds
    send_string('{8'h7E, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hF0, 8'h90, 8'h80, 8'h80}, 1'b0);
  endtask

  task automatic test_rejected_bytes();
    // Overlong, surrogate and out-of-range second bytes
    send_string('{8'hE0, 8'h9F}, 1'b1);
    send_string('{8'hED, 8'hA0}, 1'b1);
    send_string('{8'hF0, 8'h8F}, 1'b1);
    send_string('{8'hF4, 8'h90}, 1'b1);
    // Bad lead holds the count reached before it
    send_string('{8'h41, 8'hC1, 8'h42}, 1'b1);
    send_string('{8'h80}, 1'b1);
    send_string('{8'h00}, 1'b1);
    send_string('{8'h7F}, 1'b1);
    // Truncated character
    send_string('{8'hC2}, 1'b0);
  endtask

  task automatic test_limit_extremes();
    set_limit(11'd1);
    send_string('{8'h41}, 1'b1);
    send_string('{8'h41, 8'h42}, 1'b1);
    set_limit(11'd0);
    send_string('{8'hC3, 8'hA9}, 1'b1);
    // Exactly at the limit, then one past it
    set_limit(11'd20);
    send_ascii_run(20);
    send_ascii_run(21);
    set_limit(11'd1024);
    send_string('{8'h41, 8'hC3, 8'hA9}, 1'b1);
  endtask

  task automatic test_random_strings(input int target);
    int start;
    start    = items_sent;
    noise_on = 1'b1;
    while (items_sent - start < target) begin
      case ($urandom_range(0, 9))
        0: case ($urandom_range(0, 3))
             0: set_limit(11'd0);
             1: set_limit(11'd1);
             2: set_limit(11'd1024);
             default: set_limit(11'd2047);
           endcase
        1: set_limit(COUNT_W'($urandom_range(1025, 2047)));
        2: set_limit(COUNT_W'($urandom_range(31, 1024)));
        default: set_limit(COUNT_W'($urandom_range(1, 30)));
      endcase
      idle_on = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(3, 10)) send_random_string();
    end
  endtask

  task automatic test_back_to_back(input int target);
    int start;
    start   = items_sent;
    idle_on = 1'b0;
    while (items_sent - start < target) send_random_string();
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    limit_q     = LIMIT_RESET;
    clear_string();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_well_formed();
    test_rejected_bytes();
    test_limit_extremes();
    test_random_strings(700);
    test_back_to_back(150);

    // Drain, then give the pipeline time to show anything unexpected
    in_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
